// File: src/rrts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task slot scheduler: shared definitions
// Slot table entry, event and result codes, controller commands and status.
// ----------------------------------------------------------------------------
package rrts_pkg;

    localparam int SLOTS_DEF = 16;
    localparam int TALLY_W = 32;
    localparam int S_DATA_W = 72;
    localparam int S_USER_W = 2;
    localparam int M_DATA_W = 112;
    localparam int M_USER_W = 3;
    localparam logic [63:0] CANARY_BASE = 64'h7461736b7374616b;

    typedef enum logic [1:0] {
        MODE_CREATE,
        MODE_YIELD,
        MODE_EXIT,
        MODE_REAP
    } t_mode;

    typedef enum logic [1:0] {
        ST_UNUSED,
        ST_READY,
        ST_RUNNING,
        ST_FINISHED
    } t_slot_st;

    typedef enum logic [2:0] {
        STS_OK,
        STS_REJECTED,
        STS_NO_SLOT,
        STS_NO_STACK,
        STS_CORRUPTED,
        STS_FREE_FAILED,
        STS_NO_READY
    } t_status;

    typedef struct packed {
        logic [TALLY_W-1:0] tally;
        logic               bad;
        t_slot_st           st;
    } t_entry;

    // what the datapath writes into the slot table
    typedef enum logic [2:0] {
        WS_MARK_FIN,
        WS_FREE,
        WS_CREATE,
        WS_RUN,
        WS_READY_OLD
    } t_wsel;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DISP,
        S_CHK,
        S_SCAN,
        S_REL,
        S_SWITCH,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic    load_in;
        logic    rd_issue;
        logic    rd_target;
        logic    chk_cap;
        logic    scan_start;
        logic    scan_free;
        logic    scan_run;
        logic    wr_en;
        t_wsel   wsel;
        logic    st_we;
        t_status st_code;
        logic    out_load;
    } t_cmd;

    typedef struct packed {
        t_mode mode;
        logic  entry;
        logic  granted;
        logic  released;
        logic  act_zero;
        logic  tgt_bad;
        logic  chk_fin;
        logic  chk_bad;
        logic  cur_running;
        logic  scan_hit;
        logic  scan_none;
        logic  out_free;
    } t_stat;

endpackage

// File: src/rrts_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write and one read port, read data registered and held when idle.
// ----------------------------------------------------------------------------
module rrts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: src/rrts_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler datapath
// Slot table memory with reset-valid bits, slot scan pointer, canary compare,
// running-slot registers and the result register.
// ----------------------------------------------------------------------------
module rrts_dp #(
    parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  rrts_pkg::t_cmd                i_cmd,
    output rrts_pkg::t_stat               o_stat,
    input  logic [rrts_pkg::S_DATA_W-1:0] s_tdata,
    input  logic [rrts_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [rrts_pkg::M_DATA_W-1:0] m_tdata,
    output logic [rrts_pkg::M_USER_W-1:0] m_tuser
);

    localparam int SW = $clog2(SLOTS);
    localparam int EW = $bits(rrts_pkg::t_entry);

    // latched item
    rrts_pkg::t_mode r_mode;
    logic [3:0]      r_target;
    logic            r_entry;
    logic            r_granted;
    logic            r_released;
    logic [63:0]     r_word;

    logic [SW-1:0]                  r_active;
    logic [rrts_pkg::TALLY_W-1:0]   r_act_tally;
    logic [SLOTS-1:0]               r_vld;
    logic [SW-1:0]                  r_rd_addr;
    logic                           r_rd_vld;
    logic                           r_tag;
    logic [SW-1:0]                  r_ptr;
    logic [SW-1:0]                  r_cnt;
    logic                           r_kind_free;
    rrts_pkg::t_entry               r_cur;
    rrts_pkg::t_status              r_st;
    logic [SW-1:0]                  r_res;
    logic                           r_sw;
    logic [63:0]                    r_canary;
    logic                           r_o_valid;
    logic [rrts_pkg::M_DATA_W-1:0]  r_o_tdata;
    logic [rrts_pkg::M_USER_W-1:0]  r_o_tuser;

    logic [EW-1:0]    ram_q;
    rrts_pkg::t_entry rd_entry;
    rrts_pkg::t_entry rst_entry;
    rrts_pkg::t_entry wr_data;
    logic [SW-1:0]    wr_addr;
    logic [SW-1:0]    rd_addr;
    logic             rd_en;
    logic             new_bad;
    logic             match;
    logic             scan_hit;
    logic             scan_go;
    logic [SW-1:0]    tgt_idx;
    logic [SW-1:0]    ptr_next;
    logic [SW-1:0]    act_next;
    logic [SW-1:0]    res_task;

    assign tgt_idx  = SW'(r_target);
    assign ptr_next = (r_ptr == SW'(SLOTS - 1)) ? '0 : r_ptr + 1'b1;
    assign act_next = (r_active == SW'(SLOTS - 1)) ? '0 : r_active + 1'b1;

    // an entry never written reads as its reset value
    always_comb begin
        if (r_rd_addr == '0) begin
            rst_entry = '{tally: rrts_pkg::TALLY_W'(1), bad: 1'b0, st: rrts_pkg::ST_RUNNING};
        end else begin
            rst_entry = '{tally: '0, bad: 1'b0, st: rrts_pkg::ST_UNUSED};
        end
    end

    assign rd_entry = r_rd_vld ? rrts_pkg::t_entry'(ram_q) : rst_entry;

    // slot 0 owns no stack, so its canary never fails
    assign new_bad = rd_entry.bad | ((r_rd_addr != '0) &&
                     (r_word != (rrts_pkg::CANARY_BASE ^ 64'(r_rd_addr))));

    assign match    = r_kind_free ? (rd_entry.st == rrts_pkg::ST_UNUSED)
                                  : (rd_entry.st == rrts_pkg::ST_READY);
    assign scan_hit = r_tag && match;
    assign scan_go  = i_cmd.scan_run && (r_cnt != '0) && !scan_hit;

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = r_ptr;
        if (i_cmd.rd_issue) begin
            rd_en   = 1'b1;
            rd_addr = i_cmd.rd_target ? tgt_idx : r_active;
        end else if (scan_go) begin
            rd_en = 1'b1;
        end
    end

    always_comb begin
        wr_addr = r_rd_addr;
        wr_data = '{tally: '0, bad: 1'b0, st: rrts_pkg::ST_UNUSED};
        unique case (i_cmd.wsel)
            rrts_pkg::WS_MARK_FIN: begin
                wr_data = '{tally: rd_entry.tally, bad: new_bad, st: rrts_pkg::ST_FINISHED};
            end
            rrts_pkg::WS_FREE: begin
                wr_data = '{tally: '0, bad: 1'b0, st: rrts_pkg::ST_UNUSED};
            end
            rrts_pkg::WS_CREATE: begin
                wr_data = '{tally: '0, bad: 1'b0, st: rrts_pkg::ST_READY};
            end
            rrts_pkg::WS_RUN: begin
                wr_data = '{tally: rd_entry.tally + 1'b1, bad: rd_entry.bad,
                            st: rrts_pkg::ST_RUNNING};
            end
            rrts_pkg::WS_READY_OLD: begin
                wr_addr = r_active;
                wr_data = '{tally: r_cur.tally, bad: r_cur.bad, st: rrts_pkg::ST_READY};
            end
            default: begin
                wr_addr = r_rd_addr;
            end
        endcase
    end

    rrts_ram #(
        .WIDTH (EW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.wr_en),
        .i_waddr (wr_addr),
        .i_wdata (wr_data),
        .i_re    (rd_en),
        .i_raddr (rd_addr),
        .o_rdata (ram_q)
    );

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_mode     <= rrts_pkg::t_mode'(s_tuser[1:0]);
            r_target   <= s_tdata[3:0];
            r_entry    <= s_tdata[4];
            r_granted  <= s_tdata[5];
            r_released <= s_tdata[6];
            r_word     <= s_tdata[70:7];
        end
        if (rd_en) begin
            r_rd_addr <= rd_addr;
            r_rd_vld  <= r_vld[rd_addr];
        end
        if (i_cmd.scan_start) begin
            r_ptr       <= i_cmd.scan_free ? SW'(1) : act_next;
            r_cnt       <= SW'(SLOTS - 1);
            r_kind_free <= i_cmd.scan_free;
        end else if (scan_go) begin
            r_ptr <= ptr_next;
            r_cnt <= r_cnt - 1'b1;
        end
        if (i_cmd.chk_cap) begin
            r_cur <= rd_entry;
        end
        if (i_cmd.load_in) begin
            r_st     <= rrts_pkg::STS_OK;
            r_res    <= '0;
            r_sw     <= 1'b0;
            r_canary <= '0;
        end else begin
            if (i_cmd.st_we) begin
                r_st <= i_cmd.st_code;
            end
            if (i_cmd.wr_en && i_cmd.wsel == rrts_pkg::WS_CREATE) begin
                r_res    <= r_rd_addr;
                r_canary <= rrts_pkg::CANARY_BASE ^ 64'(r_rd_addr);
            end
            if (i_cmd.wr_en && i_cmd.wsel == rrts_pkg::WS_RUN) begin
                r_sw <= 1'b1;
            end
        end
        if (i_cmd.out_load) begin
            r_o_tuser <= r_st;
            r_o_tdata <= {7'd0, r_act_tally, r_canary, r_sw, 4'(r_active), 4'(res_task)};
        end
    end

    assign res_task = (r_mode == rrts_pkg::MODE_CREATE) ? r_res : r_active;

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= '0;
            r_act_tally <= rrts_pkg::TALLY_W'(1);
            r_vld       <= '0;
            r_tag       <= 1'b0;
            r_o_valid   <= 1'b0;
        end else begin
            if (i_cmd.wr_en) begin
                r_vld[wr_addr] <= 1'b1;
            end
            if (i_cmd.wr_en && i_cmd.wsel == rrts_pkg::WS_RUN) begin
                r_active    <= r_rd_addr;
                r_act_tally <= wr_data.tally;
            end
            r_tag <= scan_go;
            if (i_cmd.out_load) begin
                r_o_valid <= 1'b1;
            end else if (m_tready) begin
                r_o_valid <= 1'b0;
            end
        end
    end

    assign o_stat = '{
        mode:        r_mode,
        entry:       r_entry,
        granted:     r_granted,
        released:    r_released,
        act_zero:    (r_active == '0),
        tgt_bad:     (r_target == 4'd0) || (32'(r_target) >= SLOTS),
        chk_fin:     (rd_entry.st == rrts_pkg::ST_FINISHED),
        chk_bad:     new_bad,
        cur_running: (r_cur.st == rrts_pkg::ST_RUNNING),
        scan_hit:    scan_hit,
        scan_none:   r_tag && !match && (r_cnt == '0),
        out_free:    !r_o_valid || m_tready
    };

    assign m_tvalid = r_o_valid;
    assign m_tdata  = r_o_tdata;
    assign m_tuser  = r_o_tuser;

    a_active_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_active) < SLOTS)
        else $error("running slot outside the table");

    a_switch_active: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && i_cmd.wsel == rrts_pkg::WS_RUN) |=> (r_active == $past(r_rd_addr)))
        else $error("switch did not move the running slot");

    a_switch_tally: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.wr_en && i_cmd.wsel == rrts_pkg::WS_RUN)
        |=> (r_act_tally == $past(rd_entry.tally) + 1'b1))
        else $error("run count of new running slot not advanced");

    a_ready_scan_skips_self: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag && !r_kind_free) |-> (r_rd_addr != r_active))
        else $error("ready scan read the running slot");

    a_free_scan_skips_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_tag && r_kind_free) |-> (r_rd_addr != '0))
        else $error("free slot scan read the idle slot");

endmodule

// File: src/rrts_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Scheduler controller
// Sequences decode, canary check, slot scan, switch and result hand-off.
// ----------------------------------------------------------------------------
module rrts_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  rrts_pkg::t_stat i_stat,
    output rrts_pkg::t_cmd  o_cmd
);

    rrts_pkg::t_state r_state;
    rrts_pkg::t_state n_state;
    logic             r_corrupt;
    logic             n_corrupt;
    logic             r_path_exit;
    logic             n_path_exit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= rrts_pkg::S_IDLE;
            r_corrupt   <= 1'b0;
            r_path_exit <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_corrupt   <= n_corrupt;
            r_path_exit <= n_path_exit;
        end
    end

    always_comb begin
        n_state     = r_state;
        n_corrupt   = r_corrupt;
        n_path_exit = r_path_exit;
        o_cmd       = '0;
        s_tready    = (r_state == rrts_pkg::S_IDLE);
        unique case (r_state)
            rrts_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = rrts_pkg::S_DISP;
                end
            end
            rrts_pkg::S_DISP: begin
                unique case (i_stat.mode)
                    rrts_pkg::MODE_CREATE: begin
                        if (!i_stat.entry) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = rrts_pkg::STS_REJECTED;
                            n_state       = rrts_pkg::S_FINISH;
                        end else begin
                            o_cmd.scan_start = 1'b1;
                            o_cmd.scan_free  = 1'b1;
                            n_state          = rrts_pkg::S_SCAN;
                        end
                    end
                    rrts_pkg::MODE_YIELD, rrts_pkg::MODE_EXIT: begin
                        o_cmd.rd_issue = 1'b1;
                        n_state        = rrts_pkg::S_CHK;
                    end
                    rrts_pkg::MODE_REAP: begin
                        if (!i_stat.act_zero || i_stat.tgt_bad) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = rrts_pkg::STS_REJECTED;
                            n_state       = rrts_pkg::S_FINISH;
                        end else begin
                            o_cmd.rd_issue  = 1'b1;
                            o_cmd.rd_target = 1'b1;
                            n_state         = rrts_pkg::S_CHK;
                        end
                    end
                    default: begin
                        n_state = rrts_pkg::S_FINISH;
                    end
                endcase
            end
            rrts_pkg::S_CHK: begin
                o_cmd.chk_cap = 1'b1;
                if (i_stat.mode == rrts_pkg::MODE_REAP) begin
                    n_state     = rrts_pkg::S_FINISH;
                    o_cmd.st_we = 1'b1;
                    priority if (!i_stat.chk_fin) begin
                        o_cmd.st_code = rrts_pkg::STS_REJECTED;
                    end else if (i_stat.chk_bad) begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wsel    = rrts_pkg::WS_MARK_FIN;
                        o_cmd.st_code = rrts_pkg::STS_CORRUPTED;
                    end else if (!i_stat.released) begin
                        o_cmd.st_code = rrts_pkg::STS_FREE_FAILED;
                    end else begin
                        o_cmd.wr_en   = 1'b1;
                        o_cmd.wsel    = rrts_pkg::WS_FREE;
                        o_cmd.st_code = rrts_pkg::STS_OK;
                    end
                end else begin
                    o_cmd.scan_start = 1'b1;
                    n_state          = rrts_pkg::S_SCAN;
                    // a corrupted task that yields is retired instead
                    priority if (i_stat.mode == rrts_pkg::MODE_EXIT && !i_stat.act_zero) begin
                        o_cmd.wr_en = 1'b1;
                        o_cmd.wsel  = rrts_pkg::WS_MARK_FIN;
                        n_path_exit = 1'b1;
                        n_corrupt   = 1'b0;
                    end else if (!i_stat.act_zero && i_stat.chk_bad) begin
                        o_cmd.wr_en = 1'b1;
                        o_cmd.wsel  = rrts_pkg::WS_MARK_FIN;
                        n_path_exit = 1'b1;
                        n_corrupt   = 1'b1;
                    end else begin
                        n_path_exit = 1'b0;
                        n_corrupt   = 1'b0;
                    end
                end
            end
            rrts_pkg::S_SCAN: begin
                o_cmd.scan_run = 1'b1;
                if (i_stat.scan_hit) begin
                    if (i_stat.mode == rrts_pkg::MODE_CREATE) begin
                        n_state = rrts_pkg::S_FINISH;
                        if (!i_stat.granted) begin
                            o_cmd.st_we   = 1'b1;
                            o_cmd.st_code = rrts_pkg::STS_NO_STACK;
                        end else begin
                            o_cmd.wr_en = 1'b1;
                            o_cmd.wsel  = rrts_pkg::WS_CREATE;
                        end
                    end else if (!r_path_exit && i_stat.cur_running) begin
                        n_state = rrts_pkg::S_REL;
                    end else begin
                        n_state = rrts_pkg::S_SWITCH;
                    end
                end else if (i_stat.scan_none) begin
                    n_state     = rrts_pkg::S_FINISH;
                    o_cmd.st_we = 1'b1;
                    if (i_stat.mode == rrts_pkg::MODE_CREATE) begin
                        o_cmd.st_code = rrts_pkg::STS_NO_SLOT;
                    end else if (r_corrupt) begin
                        o_cmd.st_code = rrts_pkg::STS_CORRUPTED;
                    end else begin
                        o_cmd.st_code = rrts_pkg::STS_NO_READY;
                    end
                end
            end
            rrts_pkg::S_REL: begin
                o_cmd.wr_en = 1'b1;
                o_cmd.wsel  = rrts_pkg::WS_READY_OLD;
                n_state     = rrts_pkg::S_SWITCH;
            end
            rrts_pkg::S_SWITCH: begin
                o_cmd.wr_en   = 1'b1;
                o_cmd.wsel    = rrts_pkg::WS_RUN;
                o_cmd.st_we   = 1'b1;
                o_cmd.st_code = r_corrupt ? rrts_pkg::STS_CORRUPTED : rrts_pkg::STS_OK;
                n_state       = rrts_pkg::S_FINISH;
            end
            rrts_pkg::S_FINISH: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = rrts_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = rrts_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/round_robin_task_slot_scheduler_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Round-robin task slot scheduler
// Keeps the task slot table and the running task; takes one scheduler event
// (create, yield, exit, reap) per item and returns one result item.
// ----------------------------------------------------------------------------
// One event is handled at a time. It is decoded and then, as the event needs,
// goes through canary check, the slot scan, which reads one table entry per
// cycle from the single slot memory, release of the old task and the switch
// to the new one. The slot scan is the longest of these steps.
// A finished result waits in the output register while the next item is
// accepted. No clearing pass is needed after reset: per-slot valid bits make
// untouched entries read as their reset values.
// ----------------------------------------------------------------------------
module round_robin_task_slot_scheduler_unit #(
    parameter int SLOTS = rrts_pkg::SLOTS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // target_task[3:0], entry_present[4], stack_granted[5], page_released[6],
    // stack_word[70:7], zero[71]
    input  logic [rrts_pkg::S_DATA_W-1:0] s_tdata,
    // mode[1:0]
    input  logic [rrts_pkg::S_USER_W-1:0] s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // result_task[3:0], running_now[7:4], switched[8], canary_value[72:9],
    // runs_of_running[104:73], zero[111:105]
    output logic [rrts_pkg::M_DATA_W-1:0] m_tdata,
    // status[2:0]
    output logic [rrts_pkg::M_USER_W-1:0] m_tuser
);

    rrts_pkg::t_cmd  cmd;
    rrts_pkg::t_stat stat;

    rrts_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .i_stat   (stat),
        .o_cmd    (cmd)
    );

    rrts_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_stat   (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for the round-robin task slot scheduler
// Drives create, yield, exit and reap events over the input stream, predicts
// every result item from a local copy of the slot table and compares each
// result field by field. Directed tests cover the idle task, the create and
// reap rules, switching and a full table; random traffic runs mostly
// well-formed task lifecycles with bursty input and a stalling output side.
// ----------------------------------------------------------------------------
module tb_top;
    import rrts_pkg::*;

    localparam int NSLOT      = SLOTS_DEF;
    localparam int IDLE_LIMIT = 4000;
    localparam int MAX_BAD    = 5;

    typedef struct packed {
        t_mode       mode;
        logic [3:0]  target;
        logic        entry;
        logic        granted;
        logic        released;
        logic [63:0] word;
    } sched_evt_t;

    typedef struct {
        t_status     status;
        logic [3:0]  res_task;
        logic [3:0]  running;
        logic        switched;
        logic [63:0] canary;
        logic [31:0] runs;
    } sched_res_t;

    logic                i_clk    = 1'b0;
    logic                i_rst_n  = 1'b0;
    logic                s_tvalid = 1'b0;
    logic                s_tready;
    logic [S_DATA_W-1:0] s_tdata  = '0;
    logic [S_USER_W-1:0] s_tuser  = '0;
    logic                m_tvalid;
    logic                m_tready = 1'b0;
    logic [M_DATA_W-1:0] m_tdata;
    logic [M_USER_W-1:0] m_tuser;

    // local copy of the slot table
    t_slot_st    slot_st   [NSLOT];
    logic        slot_bad  [NSLOT];
    logic [31:0] slot_runs [NSLOT];
    int unsigned cur_slot;

    sched_res_t  due_q[$];
    int          mismatch_cnt = 0;
    int          events_sent  = 0;
    int          results_seen = 0;
    int          status_seen [7];
    int          burst_left   = 0;
    bit          tx_steady    = 1'b0;
    int          idle_cycles  = 0;
    int          rx_mode      = 0;
    int unsigned rx_cycle     = 0;

    round_robin_task_slot_scheduler_unit u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #2 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Scheduler predictor
    // ------------------------------------------------------------------
    function automatic void clear_table();
        for (int i = 0; i < NSLOT; i++) begin
            slot_st[i]   = ST_UNUSED;
            slot_bad[i]  = 1'b0;
            slot_runs[i] = '0;
        end
        slot_st[0]   = ST_RUNNING;
        slot_runs[0] = 32'd1;
        cur_slot     = 0;
    endfunction

    function automatic logic [63:0] good_word(int unsigned s);
        return CANARY_BASE ^ 64'(s);
    endfunction

    // the idle task owns no stack, so its canary always passes
    function automatic void mark_canary(int unsigned s, logic [63:0] word);
        if (s != 0 && s < NSLOT && !slot_bad[s] && word != good_word(s))
            slot_bad[s] = 1'b1;
    endfunction

    function automatic int unsigned next_ready_slot();
        int unsigned c;
        for (int unsigned d = 1; d < NSLOT; d++) begin
            c = (cur_slot + d) % NSLOT;
            if (slot_st[c] == ST_READY)
                return c;
        end
        return NSLOT;
    endfunction

    function automatic void run_slot(int unsigned n);
        slot_st[n]   = ST_RUNNING;
        slot_runs[n] = slot_runs[n] + 32'd1;
        cur_slot     = n;
    endfunction

    function automatic bit retire_running(logic [63:0] word);
        int unsigned n;
        mark_canary(cur_slot, word);
        slot_st[cur_slot] = ST_FINISHED;
        n = next_ready_slot();
        if (n >= NSLOT)
            return 1'b0;
        run_slot(n);
        return 1'b1;
    endfunction

    function automatic bit yield_running(logic [63:0] word, output t_status st);
        int unsigned n;
        mark_canary(cur_slot, word);
        // a corrupted task is thrown out instead of yielding
        if (cur_slot != 0 && slot_bad[cur_slot]) begin
            st = STS_CORRUPTED;
            return retire_running(word);
        end
        n = next_ready_slot();
        if (n >= NSLOT) begin
            st = STS_NO_READY;
            return 1'b0;
        end
        if (slot_st[cur_slot] == ST_RUNNING)
            slot_st[cur_slot] = ST_READY;
        run_slot(n);
        st = STS_OK;
        return 1'b1;
    endfunction

    function automatic sched_res_t schedule_event(sched_evt_t ev);
        sched_res_t  r;
        int unsigned s;
        int unsigned tgt;
        t_status     st;
        bit          sw;
        bit          res_running;
        st          = STS_OK;
        sw          = 1'b0;
        res_running = 1'b1;
        tgt         = ev.target;
        r.canary    = '0;
        r.res_task  = '0;
        case (ev.mode)
            MODE_CREATE: begin
                res_running = 1'b0;
                if (!ev.entry) begin
                    st = STS_REJECTED;
                end else begin
                    s = 1;
                    while (s < NSLOT && slot_st[s] != ST_UNUSED)
                        s++;
                    if (s >= NSLOT) begin
                        st = STS_NO_SLOT;
                    end else if (!ev.granted) begin
                        st = STS_NO_STACK;
                    end else begin
                        slot_st[s]   = ST_READY;
                        slot_bad[s]  = 1'b0;
                        slot_runs[s] = '0;
                        r.canary     = good_word(s);
                        r.res_task   = s[3:0];
                    end
                end
            end
            MODE_YIELD: begin
                sw = yield_running(ev.word, st);
            end
            MODE_EXIT: begin
                // exit from the idle task counts as one yield
                if (cur_slot == 0) begin
                    sw = yield_running(ev.word, st);
                end else begin
                    sw = retire_running(ev.word);
                    st = sw ? STS_OK : STS_NO_READY;
                end
            end
            default: begin
                if (cur_slot != 0 || tgt == 0 || tgt >= NSLOT ||
                        slot_st[tgt] != ST_FINISHED) begin
                    st = STS_REJECTED;
                end else begin
                    mark_canary(tgt, ev.word);
                    if (slot_bad[tgt]) begin
                        st = STS_CORRUPTED;
                    end else if (!ev.released) begin
                        st = STS_FREE_FAILED;
                    end else begin
                        slot_st[tgt]   = ST_UNUSED;
                        slot_bad[tgt]  = 1'b0;
                        slot_runs[tgt] = '0;
                    end
                end
            end
        endcase
        if (res_running)
            r.res_task = cur_slot[3:0];
        r.status   = st;
        r.running  = cur_slot[3:0];
        r.switched = sw;
        r.runs     = slot_runs[cur_slot];
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic sched_evt_t make_event(t_mode m, logic [3:0] tgt, bit entry,
                                              bit granted, bit released,
                                              logic [63:0] word);
        sched_evt_t ev;
        ev.mode     = m;
        ev.target   = tgt;
        ev.entry    = entry;
        ev.granted  = granted;
        ev.released = released;
        ev.word     = word;
        return ev;
    endfunction

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // corrupted slots can never be reaped, so keep their number low
    function automatic bit corrupt_ok();
        int n;
        n = 0;
        for (int i = 1; i < NSLOT; i++)
            n += slot_bad[i];
        return n < MAX_BAD;
    endfunction

    function automatic logic [63:0] word_for(int unsigned s);
        if (s == 0)
            return rand_word();
        if (corrupt_ok() && $urandom_range(0, 39) == 0)
            return $urandom_range(0, 1) ? rand_word()
                                        : good_word(s) ^ (64'd1 << $urandom_range(0, 63));
        return good_word(s);
    endfunction

    function automatic bit has_unused();
        for (int i = 1; i < NSLOT; i++)
            if (slot_st[i] == ST_UNUSED)
                return 1'b1;
        return 1'b0;
    endfunction

    function automatic sched_evt_t make_random_event();
        sched_evt_t ev;
        int         r;
        int         fin_q[$];
        ev.mode     = t_mode'($urandom_range(0, 3));
        ev.target   = 4'($urandom_range(0, 15));
        ev.entry    = 1'($urandom_range(0, 1));
        ev.granted  = 1'($urandom_range(0, 1));
        ev.released = 1'($urandom_range(0, 1));
        r           = $urandom_range(0, 99);
        if (r < 6) begin
            // noise: any fields, but keep canary damage within budget
            case (ev.mode)
                MODE_CREATE: ev.word = rand_word();
                MODE_REAP:   ev.word = word_for(ev.target);
                default:     ev.word = word_for(cur_slot);
            endcase
            return ev;
        end
        r = $urandom_range(0, 99);
        if (cur_slot == 0) begin
            if (r < (has_unused() ? 35 : 8))
                ev.mode = MODE_CREATE;
            else if (r < 70)
                ev.mode = $urandom_range(0, 1) ? MODE_YIELD : MODE_EXIT;
            else
                ev.mode = MODE_REAP;
        end else begin
            if (r < 50)
                ev.mode = MODE_YIELD;
            else if (r < 80)
                ev.mode = MODE_EXIT;
            else if (r < 90)
                ev.mode = MODE_CREATE;
            else
                ev.mode = MODE_REAP;
        end
        case (ev.mode)
            MODE_CREATE: begin
                ev.entry   = ($urandom_range(0, 15) != 0);
                ev.granted = ($urandom_range(0, 15) != 0);
                ev.word    = rand_word();
            end
            MODE_REAP: begin
                for (int i = 1; i < NSLOT; i++)
                    if (slot_st[i] == ST_FINISHED)
                        fin_q.push_back(i);
                if (fin_q.size() > 0 && $urandom_range(0, 7) != 0)
                    ev.target = 4'(fin_q[$urandom_range(0, fin_q.size() - 1)]);
                ev.released = ($urandom_range(0, 7) != 0);
                ev.word     = word_for(ev.target);
            end
            default: begin
                ev.word = word_for(cur_slot);
            end
        endcase
        return ev;
    endfunction

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_event(input sched_evt_t ev);
        int gap;
        s_tdata  <= {1'b0, ev.word, ev.released, ev.granted, ev.entry, ev.target};
        s_tuser  <= ev.mode;
        s_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_tready);
        due_q.push_back(schedule_event(ev));
        events_sent++;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap = tx_steady ? 0 : $urandom_range(0, 6);
            // hold valid high when no gap follows
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(0, 8);
        end
    endtask

    // hold off until every pending result has come back
    task automatic wait_drained();
        if (s_tvalid)
            s_tvalid <= 1'b0;
        do @(posedge i_clk); while (due_q.size() != 0);
        burst_left = 0;
    endtask

    // ------------------------------------------------------------------
    // Output side: stall pattern and result check
    // ------------------------------------------------------------------
    function automatic void cmp_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, act_v);
            mismatch_cnt++;
        end
    endfunction

    always @(posedge i_clk) begin
        sched_res_t want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (m_tuser < 7)
                    status_seen[m_tuser]++;
                if (due_q.size() == 0) begin
                    $error("result item with nothing pending: tuser 0x%0h tdata 0x%0h",
                           m_tuser, m_tdata);
                    mismatch_cnt++;
                end else begin
                    want = due_q.pop_front();
                    cmp_field("status", want.status, m_tuser[2:0]);
                    cmp_field("result_task", want.res_task, m_tdata[3:0]);
                    cmp_field("running_now", want.running, m_tdata[7:4]);
                    cmp_field("switched", want.switched, m_tdata[8]);
                    cmp_field("canary_value", want.canary, m_tdata[72:9]);
                    cmp_field("runs_of_running", want.runs, m_tdata[104:73]);
                end
            end
            rx_cycle++;
            if (rx_cycle % 128 == 0)
                rx_mode = $urandom_range(0, 3);
            case (rx_mode)
                0:       m_tready <= 1'b1;
                1:       m_tready <= 1'($urandom_range(0, 1));
                2:       m_tready <= ($urandom_range(0, 3) == 0);
                default: m_tready <= ((rx_cycle % 8) < 5);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("no item moved for %0d cycles", IDLE_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_idle_task();
        // nothing ready: yield and exit from the idle task have nowhere to go
        send_event(make_event(MODE_YIELD, 4'd0, 1'b0, 1'b0, 1'b0, '0));
        send_event(make_event(MODE_EXIT, 4'd15, 1'b1, 1'b1, 1'b1, '1));
        send_event(make_event(MODE_REAP, 4'd0, 1'b1, 1'b1, 1'b1, good_word(0)));
        send_event(make_event(MODE_REAP, 4'd15, 1'b0, 1'b0, 1'b1, good_word(15)));
    endtask

    task automatic test_create_rules();
        send_event(make_event(MODE_CREATE, 4'd0, 1'b0, 1'b1, 1'b0, '0));
        send_event(make_event(MODE_CREATE, 4'd15, 1'b1, 1'b0, 1'b1, '1));
        for (int i = 0; i < 3; i++)
            send_event(make_event(MODE_CREATE, 4'(i), 1'b1, 1'b1, 1'b0, rand_word()));
    endtask

    task automatic test_switching();
        // the idle task passes any stack word
        send_event(make_event(MODE_YIELD, 4'd0, 1'b0, 1'b0, 1'b0, '1));
        send_event(make_event(MODE_EXIT, 4'd0, 1'b0, 1'b0, 1'b0, good_word(1)));
        // only the idle task may reap
        send_event(make_event(MODE_REAP, 4'd1, 1'b0, 1'b0, 1'b1, good_word(1)));
        // bad canary on yield: task is exited and reported corrupted
        send_event(make_event(MODE_YIELD, 4'd0, 1'b0, 1'b0, 1'b0, '0));
        send_event(make_event(MODE_YIELD, 4'd0, 1'b0, 1'b0, 1'b0, good_word(3)));
        send_event(make_event(MODE_EXIT, 4'd0, 1'b0, 1'b0, 1'b0, '0));
        send_event(make_event(MODE_YIELD, 4'd0, 1'b0, 1'b0, 1'b0, good_word(3)));
    endtask

    task automatic test_reap_rules();
        send_event(make_event(MODE_REAP, 4'd1, 1'b0, 1'b0, 1'b0, good_word(1)));
        send_event(make_event(MODE_REAP, 4'd1, 1'b0, 1'b0, 1'b1, good_word(1)));
        send_event(make_event(MODE_REAP, 4'd2, 1'b0, 1'b0, 1'b1, good_word(2)));
        send_event(make_event(MODE_REAP, 4'd1, 1'b0, 1'b0, 1'b1, good_word(1)));
        // freed slot 1 is the lowest free one again
        send_event(make_event(MODE_CREATE, 4'd0, 1'b1, 1'b1, 1'b0, '0));
    endtask

    task automatic test_table_full();
        while (has_unused())
            send_event(make_event(MODE_CREATE, 4'($urandom_range(0, 15)), 1'b1, 1'b1,
                                  1'($urandom_range(0, 1)), rand_word()));
        send_event(make_event(MODE_CREATE, 4'($urandom_range(0, 15)), 1'b1,
                              1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                              rand_word()));
    endtask

    task automatic test_random_traffic(input int n_events, input bit steady);
        tx_steady = steady;
        repeat (n_events)
            send_event(make_random_event());
        tx_steady = 1'b0;
    endtask

    initial begin
        clear_table();
        for (int i = 0; i < 7; i++)
            status_seen[i] = 0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_task();
        test_create_rules();
        test_switching();
        test_reap_rules();
        wait_drained();
        test_random_traffic(600, 1'b0);
        wait_drained();
        test_table_full();
        test_random_traffic(400, 1'b1);
        wait_drained();
        test_random_traffic(700, 1'b0);

        wait_drained();
        repeat (NSLOT + 8) @(posedge i_clk);
        if (due_q.size() != 0) begin
            $error("%0d expected results never arrived", due_q.size());
            mismatch_cnt++;
        end

        $display("Sent %0d scheduler events, checked %0d results, %0d mismatches.",
                 events_sent, results_seen, mismatch_cnt);
        $display("Status mix ok/rej/noslot/nostack/corrupt/freefail/noready: %0d/%0d/%0d/%0d/%0d/%0d/%0d",
                 status_seen[0], status_seen[1], status_seen[2], status_seen[3],
                 status_seen[4], status_seen[5], status_seen[6]);
        if (mismatch_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
